// ===== rtl/core/spq_pkg.sv =====
// Shared types, sizes and codes for the stable priority record queue.
package spq_pkg;

	// Queue size and derived widths
	localparam int QUEUE_DEPTH = 16;
	localparam int IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	// Request codes
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE = 2'd1;
	localparam logic [1:0] REQ_LIST   = 2'd2;

	// Status codes
	localparam logic [2:0] STS_DONE  = 3'd0;
	localparam logic [2:0] STS_FULL  = 3'd1;
	localparam logic [2:0] STS_NONE  = 3'd2;
	localparam logic [2:0] STS_ENTRY = 3'd3;
	localparam logic [2:0] STS_EMPTY = 3'd4;

	// One stored record
	typedef struct packed {
		logic [31:0] stamp;
		logic [7:0]  prio;
		logic [7:0]  item;
		logic [15:0] borrower;
	} record_t;

	// Request word
	typedef struct packed {
		logic [1:0]  req_type;
		logic [15:0] borrower_id;
		logic [7:0]  item_id;
		logic [7:0]  prio_level;
		logic [31:0] stamp;
	} req_word_t;

	// Response word
	typedef struct packed {
		logic [2:0]  status;
		logic [15:0] out_borrower;
		logic [7:0]  out_item;
		logic [7:0]  out_prio;
		logic [31:0] out_stamp;
		logic        last;
	} rsp_word_t;

	// Control broadcast to every cell
	typedef struct packed {
		logic    ins;
		logic    rem;
		record_t key;
	} cell_ctl_t;

	// Sequencer states
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_LIST
	} seq_state_t;

endpackage

// ===== rtl/core/stable_priority_record_queue.sv =====
// Top level of the stable priority record queue: cell chain plus request sequencer.
//
//  channel | valid     | ready     | word       | moves
//  --------+-----------+-----------+------------+-------------------------------
//  request | req_valid | req_ready | req        | insert, remove or list request
//  result  | rsp_valid | rsp_ready | rsp        | status and listed record
//
// Insert and remove: the word is captured, then every cell shifts in parallel along
// the chain. A list of an empty queue captures the word and gives one result; otherwise
// capture, a setup step, then one record read out of the chain per cycle through the
// index mux while the result is not stalled.
// Reset clears the fill count and the sequencer; record contents are not reset.
// A stalled result holds the sequencer in place; a new request is taken once the
// previous one has issued its last result word into the output register.
module stable_priority_record_queue import spq_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_ready,
	input  req_word_t req,
	output logic      rsp_valid,
	input  logic      rsp_ready,
	output rsp_word_t rsp
);

	seq_state_t state_q, state_d;
	req_word_t  req_q;
	logic [CNT_W-1:0] count_q;
	logic [IDX_W-1:0] idx_q;
	rsp_word_t  rsp_q;
	logic       rsp_valid_q;

	logic out_free, do_exec, do_list, list_last, full, found;
	cell_ctl_t ctl;

	record_t recs  [QUEUE_DEPTH];
	logic    stays [QUEUE_DEPTH];
	logic    hits  [QUEUE_DEPTH];

	assign out_free  = !rsp_valid_q || rsp_ready;
	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign list_last = (CNT_W'(idx_q) == (count_q - CNT_W'(1)));

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) state_d = ST_EXEC;
			end
			ST_EXEC: begin
				if (out_free) begin
					if (req_q.req_type == REQ_LIST && count_q != '0) state_d = ST_LIST;
					else state_d = ST_IDLE;
				end
			end
			ST_LIST: begin
				if (out_free && list_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// State outputs
	always_comb begin
		req_ready = 1'b0;
		do_exec   = 1'b0;
		do_list   = 1'b0;
		case (state_q)
			ST_IDLE: req_ready = 1'b1;
			ST_EXEC: do_exec   = out_free;
			ST_LIST: do_list   = out_free;
			default: req_ready = 1'b0;
		endcase
	end

	// Broadcast the operation to the chain
	always_comb begin
		ctl.ins          = do_exec && (req_q.req_type == REQ_INSERT) && !full;
		ctl.rem          = do_exec && (req_q.req_type == REQ_REMOVE);
		ctl.key.stamp    = req_q.stamp;
		ctl.key.prio     = req_q.prio_level;
		ctl.key.item     = req_q.item_id;
		ctl.key.borrower = req_q.borrower_id;
	end

	// Cell chain
	for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
		logic    occ_i, left_stay_i, hit_in_i;
		record_t left_i, right_i;

		assign occ_i       = (CNT_W'(i) < count_q);
		assign left_stay_i = (i == 0) ? 1'b1 : stays[(i == 0) ? 0 : i - 1];
		assign left_i      = (i == 0) ? ctl.key : recs[(i == 0) ? 0 : i - 1];
		assign hit_in_i    = (i == 0) ? 1'b0 : hits[(i == 0) ? 0 : i - 1];
		assign right_i     = recs[(i == QUEUE_DEPTH - 1) ? i : i + 1];

		spq_cell u_cell (
			.clk       (clk),
			.ctl       (ctl),
			.occ       (occ_i),
			.left_stay (left_stay_i),
			.left_rec  (left_i),
			.right_rec (right_i),
			.hit_in    (hit_in_i),
			.stay      (stays[i]),
			.hit_out   (hits[i]),
			.rec       (recs[i])
		);
	end

	assign found = hits[QUEUE_DEPTH-1];

	// Capture the request word
	always_ff @(posedge clk) begin
		if (req_valid && req_ready) req_q <= req;
	end

	// Sequencer, fill count and list index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (ctl.ins) count_q <= count_q + CNT_W'(1);
			else if (ctl.rem && found) count_q <= count_q - CNT_W'(1);
			if (do_exec) idx_q <= '0;
			else if (do_list) idx_q <= idx_q + IDX_W'(1);
		end
	end

	// Output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if ((do_exec && !(req_q.req_type == REQ_LIST && count_q != '0)) || do_list) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// Output register word
	always_ff @(posedge clk) begin
		if (do_list) begin
			rsp_q.status       <= STS_ENTRY;
			rsp_q.out_borrower <= recs[idx_q].borrower;
			rsp_q.out_item     <= recs[idx_q].item;
			rsp_q.out_prio     <= recs[idx_q].prio;
			rsp_q.out_stamp    <= recs[idx_q].stamp;
			rsp_q.last         <= list_last;
		end else if (do_exec) begin
			rsp_q.out_borrower <= '0;
			rsp_q.out_item     <= '0;
			rsp_q.out_prio     <= '0;
			rsp_q.out_stamp    <= '0;
			rsp_q.last         <= 1'b1;
			case (req_q.req_type)
				REQ_INSERT: rsp_q.status <= full ? STS_FULL : STS_DONE;
				REQ_REMOVE: rsp_q.status <= found ? STS_DONE : STS_NONE;
				REQ_LIST:   rsp_q.status <= STS_EMPTY;
				default:    rsp_q.status <= STS_DONE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

// ===== rtl/core/spq_cell.sv =====
// One slot of the record chain: holds a record and trades it with its neighbors.
module spq_cell import spq_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  logic      occ,
	input  logic      left_stay,
	input  record_t   left_rec,
	input  record_t   right_rec,
	input  logic      hit_in,
	output logic      stay,
	output logic      hit_out,
	output record_t   rec
);

	record_t rec_q;

	// Keep place on insert while own priority is lower or equal
	assign stay = occ && (rec_q.prio <= ctl.key.prio);

	// Ripple the first-match flag toward the tail
	assign hit_out = hit_in ||
		(occ && (rec_q.borrower == ctl.key.borrower) && (rec_q.item == ctl.key.item));

	// Open a gap on insert, close one on remove
	always_ff @(posedge clk) begin
		if (ctl.ins && !stay) begin
			rec_q <= left_stay ? ctl.key : left_rec;
		end else if (ctl.rem && hit_out) begin
			rec_q <= right_rec;
		end
	end

	assign rec = rec_q;

endmodule
